/* sv/lcabl_pkg.sv */
// Shared types, constants and helpers for the binary-lifting common-ancestor block.
`timescale 1ns / 1ps
package lcabl_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 11;
  localparam int NODE_W    = 11;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int DEPTH_W   = 10;
  localparam int DSUM_W    = LEVELS;
  localparam int JT_DEPTH  = LEVELS << IDX_W;
  localparam int DEPTH_CAP = ((1 << LEVELS) - 1 < MAX_NODES - 1) ?
                             (1 << LEVELS) - 1 : MAX_NODES - 1;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } lcabl_kind_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_B0_RD,
    ST_B0_WR,
    ST_BK_RD1,
    ST_BK_RD2,
    ST_BK_WR,
    ST_D_RD,
    ST_D_EV,
    ST_QD0,
    ST_QD1,
    ST_QD2,
    ST_QL_RD,
    ST_QL_EV,
    ST_QCMP,
    ST_QU_RD,
    ST_QV_RD,
    ST_QEV,
    ST_QF_RD,
    ST_QF_EV
  } lcabl_state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
  } lcabl_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              status;
  } lcabl_out_t;

  function automatic logic node_ok(input logic [NODE_W-1:0] n,
                                   input logic [NODE_W-1:0] count);
    node_ok = (n != '0) && (n <= count) && (32'(n) <= 32'(MAX_NODES));
  endfunction

  // Storage index of a node numbered from one.
  function automatic logic [IDX_W-1:0] node_idx(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n - NODE_W'(1);
    node_idx = m[IDX_W-1:0];
  endfunction

endpackage

/* sv/lcabl_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module lcabl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/lca_binary_lifting.sv */
// Top level: lowest common ancestor by binary lifting, sequenced over three RAMs.
//
//   channel | ports                          | transfer
//   input   | start, busy, in_data           | start && !busy
//   result  | out_valid, out_data            | out_valid, one cycle, no stall
//   config  | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// A valid edge is written to the parent RAM as it is accepted; a clear sweeps the
// parent RAM with busy high. A valid query holds busy while it lifts and climbs;
// the jump RAM has one port, so while climbing the two nodes' jumps are read in
// turn. An out-of-range query answers the next cycle. The first query after a
// change first rebuilds jump table and depths. After reset the parent RAM is
// cleared with busy high. Results cannot be held off; each shows for exactly one
// cycle.
`timescale 1ns / 1ps
module lca_binary_lifting
  import lcabl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lcabl_in_t         in_data,
  output logic              out_valid,
  output lcabl_out_t        out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NODE_W-1:0] cfg_data
);

  localparam int JA_W = $clog2(JT_DEPTH);

  lcabl_state_t      state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [NODE_W-1:0] u_r, u_nxt, v_r, v_nxt, cur_r, cur_nxt, ju_r, ju_nxt;
  logic [DSUM_W-1:0] d_r, d_nxt, diff_r, diff_nxt;
  logic [DEPTH_W-1:0] du_r, du_nxt;
  logic [NODE_W-1:0] ncount_r, ncount_nxt;
  logic              built_r, built_nxt;
  logic              out_valid_r, out_valid_nxt;
  lcabl_out_t        out_data_r, out_data_nxt;

  logic              p_we, j_we, d_we;
  logic [IDX_W-1:0]  p_addr, d_addr;
  logic [JA_W-1:0]   j_addr;
  logic [NODE_W-1:0] p_wdata, p_rdata, j_wdata, j_rdata;
  logic [DEPTH_W-1:0] d_wdata, d_rdata;

  logic              accept, a_ok, b_ok, last_idx, lvl_top, lvl_zero;
  logic [NODE_W-1:0] node_i, ju_eff, jv_eff;
  logic [DSUM_W-1:0] d_sum;
  lcabl_kind_t       kind;

  lcabl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
  );
  lcabl_ram #(.WIDTH(NODE_W), .DEPTH(JT_DEPTH)) u_jump (
    .clk(clk), .we(j_we), .addr(j_addr), .wdata(j_wdata), .rdata(j_rdata)
  );
  lcabl_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_depth (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept   = start && !busy;
  assign kind     = lcabl_kind_t'(in_data.kind);
  assign a_ok     = node_ok(in_data.first_node, ncount_r);
  assign b_ok     = node_ok(in_data.second_node, ncount_r);
  assign last_idx = (cnt_r == IDX_W'(MAX_NODES - 1));
  assign lvl_top  = (lvl_r == LVL_W'(LEVELS - 1));
  assign lvl_zero = (lvl_r == '0);
  assign node_i   = NODE_W'({1'b0, cnt_r}) + NODE_W'(1);
  // A jump from node zero stays at zero, whatever the RAM returned.
  assign ju_eff   = (u_r == '0) ? '0 : j_rdata;
  assign jv_eff   = (v_r == '0) ? '0 : j_rdata;
  assign d_sum    = d_r + (DSUM_W'(1) << lvl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      lvl_r       <= '0;
      ncount_r    <= NODE_W'(MAX_NODES);
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lvl_r       <= lvl_nxt;
      ncount_r    <= ncount_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    cur_r      <= cur_nxt;
    ju_r       <= ju_nxt;
    d_r        <= d_nxt;
    diff_r     <= diff_nxt;
    du_r       <= du_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (last_idx) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && kind == KIND_CLEAR) begin
          state_nxt = ST_CLEAR;
        end else if (accept && kind == KIND_QUERY && a_ok && b_ok) begin
          state_nxt = built_r ? ST_QD0 : ST_B0_RD;
        end
      end
      ST_B0_RD:  state_nxt = ST_B0_WR;
      ST_B0_WR:  state_nxt = last_idx ? ST_BK_RD1 : ST_B0_RD;
      ST_BK_RD1: state_nxt = ST_BK_RD2;
      ST_BK_RD2: begin
        if (j_rdata != '0) begin
          state_nxt = ST_BK_WR;
        end else if (last_idx && lvl_r == LVL_W'(LEVELS - 2)) begin
          state_nxt = ST_D_RD;
        end else begin
          state_nxt = ST_BK_RD1;
        end
      end
      ST_BK_WR:  state_nxt = (last_idx && lvl_r == LVL_W'(LEVELS - 2)) ? ST_D_RD : ST_BK_RD1;
      ST_D_RD:   state_nxt = ST_D_EV;
      ST_D_EV:   state_nxt = (lvl_zero && last_idx) ? ST_QD0 : ST_D_RD;
      ST_QD0:    state_nxt = ST_QD1;
      ST_QD1:    state_nxt = ST_QD2;
      ST_QD2:    state_nxt = ST_QL_RD;
      ST_QL_RD: begin
        if (diff_r[lvl_r]) begin
          state_nxt = ST_QL_EV;
        end else if (lvl_top) begin
          state_nxt = ST_QCMP;
        end
      end
      ST_QL_EV:  state_nxt = lvl_top ? ST_QCMP : ST_QL_RD;
      ST_QCMP:   state_nxt = (u_r == v_r) ? ST_IDLE : ST_QU_RD;
      ST_QU_RD:  state_nxt = ST_QV_RD;
      ST_QV_RD:  state_nxt = ST_QEV;
      ST_QEV:    state_nxt = lvl_zero ? ST_QF_RD : ST_QU_RD;
      ST_QF_RD:  state_nxt = ST_QF_EV;
      ST_QF_EV:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers and RAM controls.
  always_comb begin
    cnt_nxt       = cnt_r;
    lvl_nxt       = lvl_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    cur_nxt       = cur_r;
    ju_nxt        = ju_r;
    d_nxt         = d_r;
    diff_nxt      = diff_r;
    du_nxt        = du_r;
    ncount_nxt    = ncount_r;
    built_nxt     = built_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    p_we          = 1'b0;
    p_addr        = cnt_r;
    p_wdata       = '0;
    j_we          = 1'b0;
    j_addr        = {lvl_r, cnt_r};
    j_wdata       = '0;
    d_we          = 1'b0;
    d_addr        = cnt_r;
    d_wdata       = '0;

    if (cfg_valid && cfg_ready) begin
      ncount_nxt = cfg_data;
      built_nxt  = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        p_we    = 1'b1;
        cnt_nxt = cnt_r + IDX_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_CLEAR: begin
              cnt_nxt   = '0;
              built_nxt = 1'b0;
            end
            KIND_EDGE: begin
              if (a_ok && b_ok) begin
                p_we      = 1'b1;
                p_addr    = node_idx(in_data.second_node);
                p_wdata   = in_data.first_node;
                built_nxt = 1'b0;
              end
            end
            KIND_QUERY: begin
              u_nxt   = in_data.first_node;
              v_nxt   = in_data.second_node;
              cnt_nxt = '0;
              if (!(a_ok && b_ok)) begin
                out_valid_nxt         = 1'b1;
                out_data_nxt.ancestor = '0;
                out_data_nxt.status   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_B0_WR: begin
        j_we    = 1'b1;
        j_addr  = {LVL_W'(0), cnt_r};
        j_wdata = (node_ok(node_i, ncount_r) && node_ok(p_rdata, ncount_r)) ? p_rdata : '0;
        cnt_nxt = cnt_r + IDX_W'(1);
        lvl_nxt = '0;
      end
      ST_BK_RD2: begin
        if (j_rdata != '0) begin
          j_addr = {lvl_r, node_idx(j_rdata)};
        end else begin
          j_we    = 1'b1;
          j_addr  = {lvl_r + LVL_W'(1), cnt_r};
          cnt_nxt = cnt_r + IDX_W'(1);
          if (last_idx) lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
      ST_BK_WR: begin
        j_we    = 1'b1;
        j_addr  = {lvl_r + LVL_W'(1), cnt_r};
        j_wdata = j_rdata;
        cnt_nxt = cnt_r + IDX_W'(1);
        if (last_idx) lvl_nxt = lvl_r + LVL_W'(1);
      end
      ST_D_RD: begin
        // Entering from the build, the first node's walk starts here.
        if (lvl_r != LVL_W'(LEVELS - 1) || cur_r == '0) begin
          j_addr = {lvl_r, node_idx(cur_r)};
        end
        j_addr = {lvl_r, node_idx(cur_r)};
      end
      ST_D_EV: begin
        if (j_rdata != '0) begin
          cur_nxt = j_rdata;
          d_nxt   = d_sum;
        end
        if (lvl_zero) begin
          d_we    = 1'b1;
          d_wdata = (d_nxt > DSUM_W'(DEPTH_CAP)) ? DEPTH_W'(DEPTH_CAP) : d_nxt[DEPTH_W-1:0];
          cnt_nxt = cnt_r + IDX_W'(1);
          cur_nxt = node_i + NODE_W'(1);
          d_nxt   = '0;
          lvl_nxt = LVL_W'(LEVELS - 1);
          if (last_idx) built_nxt = 1'b1;
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      ST_QD0: d_addr = node_idx(u_r);
      ST_QD1: begin
        du_nxt = d_rdata;
        d_addr = node_idx(v_r);
      end
      ST_QD2: begin
        lvl_nxt = '0;
        if (du_r > d_rdata) begin
          u_nxt    = v_r;
          v_nxt    = u_r;
          diff_nxt = DSUM_W'(du_r - d_rdata);
        end else begin
          diff_nxt = DSUM_W'(d_rdata - du_r);
        end
      end
      ST_QL_RD: begin
        j_addr = {lvl_r, node_idx(v_r)};
        if (!diff_r[lvl_r] && !lvl_top) lvl_nxt = lvl_r + LVL_W'(1);
      end
      ST_QL_EV: begin
        v_nxt = jv_eff;
        if (!lvl_top) lvl_nxt = lvl_r + LVL_W'(1);
      end
      ST_QCMP: begin
        lvl_nxt = LVL_W'(LEVELS - 1);
        if (u_r == v_r) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.ancestor = u_r;
          out_data_nxt.status   = 1'b0;
        end
      end
      ST_QU_RD: j_addr = {lvl_r, node_idx(u_r)};
      ST_QV_RD: begin
        ju_nxt = ju_eff;
        j_addr = {lvl_r, node_idx(v_r)};
      end
      ST_QEV: begin
        if (ju_r != jv_eff) begin
          u_nxt = ju_r;
          v_nxt = jv_eff;
        end
        if (!lvl_zero) lvl_nxt = lvl_r - LVL_W'(1);
      end
      ST_QF_RD: j_addr = {LVL_W'(0), node_idx(u_r)};
      ST_QF_EV: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.ancestor = ju_eff;
        out_data_nxt.status   = 1'b0;
      end
      default: ;
    endcase

    // The depth walk of the first node begins as the last level is built.
    if ((state_r == ST_BK_WR || (state_r == ST_BK_RD2 && j_rdata == '0)) &&
        last_idx && lvl_r == LVL_W'(LEVELS - 2)) begin
      cur_nxt = NODE_W'(1);
      d_nxt   = '0;
      lvl_nxt = LVL_W'(LEVELS - 1);
    end
  end

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_IDLE)
    else $error("result strobe outside idle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status) |-> out_data_r.ancestor == '0)
    else $error("error result carries a nonzero ancestor");

  a_query_built: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_QD0 |-> built_r)
    else $error("query started on stale tables");

  a_built_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> $past(state_r) == ST_D_EV)
    else $error("tables marked built outside the depth pass");

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the binary-lifting common-ancestor block.
`timescale 1ns / 1ps
module testbench;
  import lcabl_pkg::*;

  typedef enum logic [1:0] {ENT_ITEM, ENT_CFG, ENT_DRAIN} entry_kind_t;

  typedef struct {
    entry_kind_t       what;
    lcabl_in_t         item;
    logic [NODE_W-1:0] count;
  } entry_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  lcabl_in_t         in_data;
  logic              out_valid;
  lcabl_out_t        out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [NODE_W-1:0] cfg_data;

  lca_binary_lifting DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Tree model kept by the bench.
  logic [NODE_W-1:0]  node_limit;
  logic [NODE_W-1:0]  parent_of [MAX_NODES];
  logic [NODE_W-1:0]  lift [LEVELS][MAX_NODES];
  logic [DEPTH_W-1:0] depth_of [MAX_NODES];
  logic               lift_valid;

  entry_t     pending [$];
  lcabl_out_t answers [$];
  int errors = 0;
  int n_queries = 0, n_edges = 0, n_clears = 0, n_writes = 0, n_results = 0;
  int gap = 0;
  int settle = 0;

  initial clk = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic valid_node(input logic [NODE_W-1:0] n);
    return n != 0 && n <= node_limit && int'(n) <= MAX_NODES;
  endfunction

  function automatic logic [NODE_W-1:0] hop(input int lv, input logic [NODE_W-1:0] n);
    if (n == 0 || int'(n) > MAX_NODES) return '0;
    return lift[lv][n-1];
  endfunction

  task automatic rebuild_lifting();
    logic [NODE_W-1:0] cur;
    int d;
    for (int i = 1; i <= MAX_NODES; i++)
      lift[0][i-1] = (valid_node(NODE_W'(i)) && valid_node(parent_of[i-1])) ?
                     parent_of[i-1] : '0;
    for (int k = 0; k + 1 < LEVELS; k++)
      for (int i = 1; i <= MAX_NODES; i++)
        lift[k+1][i-1] = hop(k, hop(k, NODE_W'(i)));
    for (int i = 1; i <= MAX_NODES; i++) begin
      cur = NODE_W'(i);
      d = 0;
      for (int lv = LEVELS - 1; lv >= 0; lv--)
        if (hop(lv, cur) != 0) begin
          cur = hop(lv, cur);
          d += 1 << lv;
        end
      depth_of[i-1] = DEPTH_W'(d > DEPTH_CAP ? DEPTH_CAP : d);
    end
    lift_valid = 1'b1;
  endtask

  function automatic logic [NODE_W-1:0] meet(input logic [NODE_W-1:0] u,
                                             input logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] t, ju, jv;
    int du, dv, diff;
    du = depth_of[u-1];
    dv = depth_of[v-1];
    if (du > dv) begin
      t = u; u = v; v = t;
      diff = du - dv;
    end else begin
      diff = dv - du;
    end
    for (int k = 0; k < LEVELS; k++)
      if ((diff >> k) & 1) v = hop(k, v);
    if (u == v) return u;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      ju = hop(k, u);
      jv = hop(k, v);
      if (ju != jv) begin
        u = ju;
        v = jv;
      end
    end
    return hop(0, u);
  endfunction

  task automatic apply_transaction(input lcabl_in_t it);
    lcabl_out_t r;
    case (lcabl_kind_t'(it.kind))
      KIND_CLEAR: begin
        for (int i = 0; i < MAX_NODES; i++) parent_of[i] = '0;
        lift_valid = 1'b0;
        n_clears++;
      end
      KIND_EDGE: begin
        n_edges++;
        if (valid_node(it.first_node) && valid_node(it.second_node)) begin
          parent_of[it.second_node-1] = it.first_node;
          lift_valid = 1'b0;
        end
      end
      KIND_QUERY: begin
        n_queries++;
        if (!valid_node(it.first_node) || !valid_node(it.second_node)) begin
          r.ancestor = '0;
          r.status = 1'b1;
        end else begin
          if (!lift_valid) rebuild_lifting();
          r.ancestor = meet(it.first_node, it.second_node);
          r.status = 1'b0;
        end
        answers.insert(answers.size(), r);
      end
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: one transaction in flight on either the input or the register port.
  always @(posedge clk) begin
    logic nxt_start, nxt_cfg;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      in_data <= '0;
      cfg_data <= '0;
      node_limit = NODE_W'(MAX_NODES);
      lift_valid = 1'b0;
      for (int i = 0; i < MAX_NODES; i++) parent_of[i] = '0;
    end else begin
      nxt_start = start && busy;
      nxt_cfg = cfg_valid && !cfg_ready;
      if (start && !busy) apply_transaction(in_data);
      if (cfg_valid && cfg_ready) begin
        node_limit = cfg_data;
        lift_valid = 1'b0;
        n_writes++;
      end
      if (!nxt_start && !nxt_cfg && pending.size() > 0) begin
        if (gap > 0) begin
          gap--;
        end else if (pending[0].what == ENT_ITEM) begin
          nxt_start = 1'b1;
          in_data <= pending[0].item;
          void'(pending.pop_front());
          gap = gap_len();
        end else if (answers.size() == 0 && !busy) begin
          // A clear can still be sweeping after the last result, so let it finish.
          if (pending[0].what == ENT_DRAIN) begin
            void'(pending.pop_front());
          end else if (settle >= 1100) begin
            nxt_cfg = 1'b1;
            cfg_data <= pending[0].count;
            void'(pending.pop_front());
            settle = 0;
          end else begin
            settle++;
          end
        end else begin
          settle = 0;
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // Monitor: results cannot be stalled, so every strobe is checked on the spot.
  always @(posedge clk) begin
    lcabl_out_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result ancestor=%0d status=%0d", $time,
                 out_data.ancestor, out_data.status);
        errors++;
      end else begin
        want = answers.pop_front();
        if (out_data.ancestor !== want.ancestor || out_data.status !== want.status) begin
          $display("%0t: mismatch expected ancestor=%0d status=%0d, got ancestor=%0d status=%0d",
                   $time, want.ancestor, want.status, out_data.ancestor, out_data.status);
          errors++;
        end
      end
    end
  end

  task automatic push_item(input lcabl_kind_t k, input int a, input int b);
    entry_t e;
    e.what = ENT_ITEM;
    e.item.kind = k;
    e.item.first_node = NODE_W'(a);
    e.item.second_node = NODE_W'(b);
    e.count = '0;
    pending.insert(pending.size(), e);
  endtask

  task automatic push_ctrl(input entry_kind_t w, input int v);
    entry_t e;
    e.what = w;
    e.item = '0;
    e.count = NODE_W'(v);
    pending.insert(pending.size(), e);
  endtask

  initial begin
    int counts [9] = '{1, 7, 33, 1024, 200, 2047, 16, 64, 5};
    int hi, c, nb_edges;
    rst_n = 1'b0;

    // Directed part: range errors, forests, replaced links, ignored edges.
    push_item(KIND_QUERY, 0, 5);
    push_item(KIND_QUERY, 1025, 1);
    push_item(KIND_QUERY, 2047, 2047);
    push_item(KIND_NONE, 2047, 2047);
    push_item(KIND_EDGE, 1, 2);
    push_item(KIND_EDGE, 1, 3);
    push_item(KIND_EDGE, 2, 4);
    push_item(KIND_EDGE, 2, 5);
    push_item(KIND_EDGE, 3, 6);
    push_item(KIND_EDGE, 2, 0);
    push_item(KIND_EDGE, 1500, 7);
    push_item(KIND_EDGE, 3, 5);
    push_item(KIND_EDGE, 1024, 1000);
    push_item(KIND_QUERY, 4, 5);
    push_item(KIND_QUERY, 5, 6);
    push_item(KIND_QUERY, 1000, 1024);
    push_item(KIND_QUERY, 7, 4);
    push_item(KIND_QUERY, 4, 4);
    push_item(KIND_QUERY, 1024, 1024);
    push_item(KIND_QUERY, 1, 1025);
    push_ctrl(ENT_DRAIN, 0);
    push_item(KIND_CLEAR, 0, 0);

    // Random phases: mostly forests with parent below child, some noise edges.
    foreach (counts[p]) begin
      push_ctrl(ENT_CFG, counts[p]);
      hi = counts[p] > MAX_NODES ? MAX_NODES : counts[p];
      if (p != 2 && p != 7) push_item(KIND_CLEAR, 0, 0);
      nb_edges = hi < 2 ? 0 : $urandom_range(10, 25);
      for (int i = 0; i < nb_edges; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_item(KIND_EDGE, $urandom_range(0, 2047), $urandom_range(0, 2047));
        end else begin
          c = $urandom_range(2, hi > 60 ? 60 : hi);
          push_item(KIND_EDGE, $urandom_range(1, c - 1), c);
        end
      end
      if (p == 4) push_item(KIND_EDGE, 9, 9);
      for (int i = 0; i < 35; i++) begin
        if ($urandom_range(0, 19) == 0)
          push_item(KIND_NONE, $urandom_range(0, 2047), $urandom_range(0, 2047));
        else if ($urandom_range(0, 6) == 0)
          push_item(KIND_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047));
        else
          push_item(KIND_QUERY, $urandom_range(1, hi > 60 ? 60 : hi),
                    $urandom_range(1, hi > 60 ? 60 : hi));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() != 0 || start || answers.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    $display("covered %0d queries, %0d edges, %0d clears, %0d register writes", n_queries,
             n_edges, n_clears, n_writes);
    $display("checked %0d results against the tree model", n_results);
    if (errors == 0 && answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
